// ===== sv/i2ew_pkg.sv =====
// i2ew_pkg: shared word codes, sizes and controller/datapath handshake types
// for the integer-to-English-words block. No dependencies.
package i2ew_pkg;

    localparam int unsigned VALUE_W  = 31;
    localparam int unsigned CODE_W   = 5;
    localparam int unsigned BIN_W    = 32;   // value padded to an even bit count
    localparam int unsigned DIGITS   = 10;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    localparam int unsigned GROUPS   = 4;
    localparam int unsigned PHASES   = 5;
    localparam int unsigned SLOTS    = GROUPS * PHASES;
    localparam int unsigned CONV_STEPS = BIN_W / 2;
    localparam int unsigned CNT_W    = $clog2(CONV_STEPS);

    localparam logic [CODE_W-1:0] WORD_ZERO     = 5'd0;
    localparam logic [CODE_W-1:0] WORD_TEN      = 5'd10;
    localparam logic [CODE_W-1:0] TENS_BASE     = 5'd18;
    localparam logic [CODE_W-1:0] WORD_HUNDRED  = 5'd28;
    localparam logic [CODE_W-1:0] WORD_THOUSAND = 5'd29;

    // slot phases inside one group
    localparam logic [2:0] PH_HDIGIT = 3'd0;
    localparam logic [2:0] PH_HWORD  = 3'd1;
    localparam logic [2:0] PH_TENS   = 3'd2;
    localparam logic [2:0] PH_UNITS  = 3'd3;
    localparam logic [2:0] PH_SCALE  = 3'd4;

    typedef struct packed {
        logic load;
        logic conv;
        logic build;
        logic pop;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_status;

endpackage

// ===== sv/i2ew_dp.sv =====
// i2ew_dp: datapath. Double-dabble binary to BCD (two bits a cycle), slot
// mask per group, and one word out per pop. Depends on i2ew_pkg.
module i2ew_dp (
    input  logic                          i_clk,
    input  i2ew_pkg::t_cmd                i_cmd,
    input  logic [i2ew_pkg::VALUE_W-1:0]  i_value,
    output i2ew_pkg::t_status             o_status,
    output logic [i2ew_pkg::CODE_W-1:0]   o_word_code
);
    import i2ew_pkg::*;

    localparam int unsigned SW = BCD_W + BIN_W;

    logic [BIN_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [SLOTS-1:0] r_pend, n_pend;
    logic [SLOTS-1:0] w_mask;
    logic [SLOTS-1:0] w_rest;
    logic [SW-1:0]    w_s1, w_s2;
    logic [1:0]       w_sel_g;
    logic [2:0]       w_sel_p;
    logic [3:0]       w_h, w_t, w_u;

    function automatic logic [SW-1:0] f_step(input logic [SW-1:0] s);
        logic [BCD_W-1:0] b;
        b = s[SW-1:BIN_W];
        for (int i = 0; i < DIGITS; i++) begin
            if (b[4*i +: 4] >= 4'd5) begin
                b[4*i +: 4] = b[4*i +: 4] + 4'd3;
            end
        end
        return {b[BCD_W-2:0], s[BIN_W-1:0], 1'b0};
    endfunction

    function automatic logic [3:0] f_dig(input logic [BCD_W-1:0] b, input int unsigned k);
        logic [3:0] d;
        d = 4'd0;
        if (k < DIGITS) begin
            d = b[4*k +: 4];
        end
        return d;
    endfunction

    assign w_s1 = f_step({r_bcd, r_bin});
    assign w_s2 = f_step(w_s1);

    // slot k = (3 - group) * 5 + phase, earliest word in bit 0
    always_comb begin
        logic [3:0] h, t, u;
        w_mask = '0;
        for (int g = 0; g < GROUPS; g++) begin
            h = f_dig(r_bcd, 3 * g + 2);
            t = f_dig(r_bcd, 3 * g + 1);
            u = f_dig(r_bcd, 3 * g);
            w_mask[(GROUPS-1-g)*PHASES + PH_HDIGIT] = (h != 4'd0);
            w_mask[(GROUPS-1-g)*PHASES + PH_HWORD]  = (h != 4'd0);
            w_mask[(GROUPS-1-g)*PHASES + PH_TENS]   = (t != 4'd0);
            w_mask[(GROUPS-1-g)*PHASES + PH_UNITS]  = (t != 4'd1) && (u != 4'd0);
            w_mask[(GROUPS-1-g)*PHASES + PH_SCALE]  = (g != 0) && ({h, t, u} != 12'd0);
        end
        // zero input: units slot of the unit group reads out Zero
        if (w_mask == '0) begin
            w_mask[(GROUPS-1)*PHASES + PH_UNITS] = 1'b1;
        end
    end

    always_comb begin
        w_sel_g = 2'd0;
        w_sel_p = PH_HDIGIT;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                w_sel_g = 2'(GROUPS - 1 - (k / PHASES));
                w_sel_p = 3'(k % PHASES);
            end
        end
    end

    always_comb begin
        w_u = r_bcd[12*w_sel_g +: 4];
        w_t = 4'd0;
        w_h = 4'd0;
        if (w_sel_g != 2'd3) begin
            w_t = r_bcd[12*w_sel_g + 4 +: 4];
            w_h = r_bcd[12*w_sel_g + 8 +: 4];
        end
    end

    always_comb begin
        unique case (w_sel_p)
            PH_HDIGIT: o_word_code = {1'b0, w_h};
            PH_HWORD:  o_word_code = WORD_HUNDRED;
            PH_TENS:   o_word_code = (w_t == 4'd1) ? (WORD_TEN + {1'b0, w_u})
                                                   : (TENS_BASE + {1'b0, w_t});
            PH_UNITS:  o_word_code = {1'b0, w_u};
            PH_SCALE:  o_word_code = WORD_HUNDRED + {3'd0, w_sel_g};
            default:   o_word_code = WORD_ZERO;
        endcase
    end

    assign w_rest        = r_pend & (r_pend - 1'b1);
    assign o_status.last = (w_rest == '0);

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_pend = r_pend;
        if (i_cmd.load) begin
            n_bin = {1'b0, i_value};
            n_bcd = '0;
        end else if (i_cmd.conv) begin
            n_bcd = w_s2[SW-1:BIN_W];
            n_bin = w_s2[BIN_W-1:0];
        end
        if (i_cmd.build) begin
            n_pend = w_mask;
        end else if (i_cmd.pop) begin
            n_pend = w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_pend <= n_pend;
    end

endmodule

// ===== sv/i2ew_ctrl.sv =====
// i2ew_ctrl: controller state machine, handshakes and conversion step count.
// Depends on i2ew_pkg.
module i2ew_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    input  i2ew_pkg::t_status  i_status,
    output i2ew_pkg::t_cmd     o_cmd
);
    import i2ew_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;
    localparam logic [1:0] S_BUILD = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_EMIT);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CONV_STEPS - 1)) begin
                    n_state = S_BUILD;
                end
            end
            S_BUILD: begin
                o_cmd.build = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_ready) begin
                    o_cmd.pop = 1'b1;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sv/integer_to_english_words_core.sv =====
// integer_to_english_words_core: top level, controller plus datapath.
// Depends on i2ew_pkg, i2ew_ctrl, i2ew_dp.
//
// Reads a 31-bit unsigned value out as a run of English word codes.
// Input channel: i_valid / o_ready with i_value. One item is taken only
// while the block is idle (o_ready high).
// Output channel: o_valid / i_ready with o_word_code and o_last_word;
// one word per accepted transfer, most significant first, o_last_word
// high on the final word. Zero reads out as the single word Zero.
// Sequence: after an item is accepted, the BCD conversion (two bits per
// cycle through the double-dabble unit) runs, then the word slot mask is
// built, and then the first word shows. Then one word per cycle while
// i_ready is high, 1 to 16 words. The next item is taken only after the
// last word of this one has been accepted.
// A stalled receiver holds o_valid and the current word steady.
// Reset (i_rst_n low, synchronous) returns the block to idle and drops
// any reading in progress.
module integer_to_english_words_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [i2ew_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [i2ew_pkg::CODE_W-1:0]   o_word_code,
    output logic                          o_last_word
);
    import i2ew_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    i2ew_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    i2ew_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_value     (i_value),
        .o_status    (w_status),
        .o_word_code (o_word_code)
    );

    assign o_last_word = w_status.last;

endmodule

// ===== sv/i2ew_checker.sv =====
// i2ew_checker: port-level assertions for integer_to_english_words_core,
// bound to the top level. Depends on i2ew_pkg.
module i2ew_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [i2ew_pkg::CODE_W-1:0]   o_word_code,
    input logic                          o_last_word
);
    import i2ew_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word_code) && $stable(o_last_word))
        else $error("output item changed while stalled");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input taken while words are pending");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready && !o_valid)
        else $error("block not busy after taking an item");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_word |=> !o_valid && o_ready)
        else $error("words continue after the last one");

endmodule

bind integer_to_english_words_core i2ew_checker u_i2ew_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_word_code (o_word_code),
    .o_last_word (o_last_word)
);
